@@ src/smf_pkg.sv @@
// Shared widths and cell types for the sliding-window median filter.
`default_nettype none
package smf_pkg;

   localparam int WINDOW_SIZE = 8;
   localparam int SAMPLE_W    = 16;
   localparam int POS_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);

   // One sorted slot: the sample and the ring position it was written at.
   typedef struct packed {
      logic                valid;
      logic [SAMPLE_W-1:0] value;
      logic [POS_W-1:0]    tag;
   } smf_entry_type;

   // Handed from cell i to cell i+1 each cycle.
   typedef struct packed {
      logic          gone;   // the evicted entry sits at or below this cell
      smf_entry_type post;   // this cell's content after eviction
   } smf_link_type;

endpackage
`default_nettype wire

@@ src/smf_cell.sv @@
// One slot of the sorted chain: evicts the oldest sample and inserts the new one.
`default_nettype none
module smf_cell
   import smf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire logic                full,
   input  wire logic [POS_W-1:0]    wpos,
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire smf_link_type        lower_in,
   input  wire smf_entry_type       up_entry,
   output smf_link_type             link_out,
   output smf_entry_type            entry_out
);

   smf_entry_type entry_ff;
   smf_entry_type entry_in;
   smf_entry_type post;
   logic          del;
   logic          gone;
   logic          gt_self;
   logic          lower_le;

   always_comb begin
      del      = full & entry_ff.valid & (entry_ff.tag == wpos);
      gone     = lower_in.gone | del;
      // once the evicted slot is at or below us, everything above moves down one
      post     = gone ? up_entry : entry_ff;
      gt_self  = !post.valid || (post.value > sample);
      lower_le = lower_in.post.valid && (lower_in.post.value <= sample);
      if (!gt_self) begin
         entry_in = post;
      end else if (lower_le) begin
         entry_in.valid = 1'b1;
         entry_in.value = sample;
         entry_in.tag   = wpos;
      end else begin
         entry_in = lower_in.post;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (load) begin
         entry_ff <= entry_in;
      end
   end

   assign link_out.gone = gone;
   assign link_out.post = post;
   assign entry_out     = entry_ff;

endmodule
`default_nettype wire

@@ src/sliding_window_median_filter_unit.sv @@
// Top level: sorted cell chain, ring position, fill count and result register.
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   req_sample[15:0]
//   rsp       out         rsp_valid/rsp_stall   rsp_median[15:0]
//
// One item per clock sustained while rsp_stall stays low. An accepted item
// updates the whole cell chain at its accepting edge; its median is picked from
// the chain once the result register is free and held there, raising rsp_valid.
// Reset empties the chain (valid bits only) and zeroes position and count.
// A stalled result holds; a second item then waits in the chain and req_stall
// rises until the result register frees up.
`default_nettype none
module sliding_window_median_filter_unit
   import smf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [SAMPLE_W-1:0]      rsp_median
);

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [POS_W-1:0]    wpos_ff, wpos_in;
   logic [POS_W-1:0]    med_idx_ff, med_idx_in;
   logic                pend_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_median_ff;
   logic                full;
   logic                accept;
   logic                load_out;

   smf_entry_type ent [WINDOW_SIZE];
   smf_link_type  links [WINDOW_SIZE+1];

   assign full     = (count_ff == CNT_W'(WINDOW_SIZE));
   assign load_out = pend_ff & (!rsp_valid_ff | !rsp_stall);
   assign req_stall = pend_ff & !load_out;
   assign accept   = req_valid & !req_stall;

   always_comb begin
      count_in = full ? count_ff : count_ff + CNT_W'(1);
      wpos_in  = (wpos_ff == POS_W'(WINDOW_SIZE - 1)) ? '0 : wpos_ff + POS_W'(1);
      // rank count/2 of the count after this item
      med_idx_in = POS_W'(count_in >> 1);
   end

   // below cell 0 sits an always-valid zero, which never exceeds a sample
   assign links[0].gone       = 1'b0;
   assign links[0].post.valid = 1'b1;
   assign links[0].post.value = '0;
   assign links[0].post.tag   = '0;

   for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
      smf_entry_type up;
      if (i == WINDOW_SIZE - 1) begin : g_top
         assign up = '0;
      end else begin : g_mid
         assign up = ent[i+1];
      end
      smf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (accept),
         .full      (full),
         .wpos      (wpos_ff),
         .sample    (req_sample),
         .lower_in  (links[i]),
         .up_entry  (up),
         .link_out  (links[i+1]),
         .entry_out (ent[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         wpos_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
            wpos_ff  <= wpos_in;
         end
         pend_ff <= accept | (pend_ff & !load_out);
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         med_idx_ff <= med_idx_in;
      end
      if (load_out) begin
         rsp_median_ff <= ent[med_idx_ff].value;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

endmodule
`default_nettype wire

@@ dv/median_window_checker.sv @@
// Checker: running window median prediction and comparison against each result item.
module median_window_checker
   import smf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [SAMPLE_W-1:0] rsp_median,
   output int                  fail_count,
   output int                  pending,
   output int                  medians_checked
);

   localparam int MAX_REPORTS = 10;

   logic [SAMPLE_W-1:0] window_q [WINDOW_SIZE];
   logic [SAMPLE_W-1:0] pending_medians [$];
   logic [SAMPLE_W-1:0] want;
   int unsigned         wr_pos;
   int unsigned         filled;
   int                  errors;
   int                  checked;

   // Only entries 0..filled-1 have been written; writes start at position 0.
   function automatic logic [SAMPLE_W-1:0] window_median();
      logic [SAMPLE_W-1:0] ranked [WINDOW_SIZE];
      logic [SAMPLE_W-1:0] key;
      int                  j;
      for (int i = 0; i < filled; i++) begin
         ranked[i] = window_q[i];
      end
      for (int i = 1; i < filled; i++) begin
         key = ranked[i];
         j = i;
         while (j > 0 && ranked[j-1] > key) begin
            ranked[j] = ranked[j-1];
            j--;
         end
         ranked[j] = key;
      end
      return ranked[filled / 2];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         wr_pos = 0;
         filled = 0;
         pending_medians.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_medians.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("unexpected median item %h, nothing pending", rsp_median);
            end else begin
               want = pending_medians.pop_front();
               checked++;
               if (rsp_median !== want) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("median mismatch: expected %h, got %h", want, rsp_median);
               end
            end
         end
         if (req_valid && !req_stall) begin
            window_q[wr_pos] = req_sample;
            wr_pos = (wr_pos + 1) % WINDOW_SIZE;
            if (filled < WINDOW_SIZE)
               filled++;
            pending_medians.push_back(window_median());
         end
      end
      pending         <= pending_medians.size();
      fail_count      <= errors;
      medians_checked <= checked;
   end

endmodule

@@ dv/tb_top.sv @@
// Testbench top: stimulus, random idling, watchdog and verdict for the median filter.
module tb_top;
   import smf_pkg::*;

   localparam int ITEM_TARGET = 1400;
   localparam int MAX_WAIT    = 13;
   localparam int IDLE_LIMIT  = 3000;
   localparam int TAIL_CYCLES = 10;

   typedef enum int {MIX_UNIFORM, MIX_CLUSTER, MIX_EXTREME, MIX_RISING, MIX_FALLING}
      sample_mix_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_valid  = 1'b0;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                rsp_stall  = 1'b0;
   logic                req_stall;
   logic                rsp_valid;
   logic [SAMPLE_W-1:0] rsp_median;

   int          fail_count;
   int          pending;
   int          medians_checked;
   int          idle_cycles  = 0;
   int          samples_sent = 0;
   int unsigned hold_left    = 0;
   bit          gaps_on      = 1'b1;
   bit          stalls_on    = 1'b1;

   sliding_window_median_filter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_median (rsp_median)
   );

   median_window_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_median      (rsp_median),
      .fail_count      (fail_count),
      .pending         (pending),
      .medians_checked (medians_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: a fresh stall count is drawn each time a result item is taken.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         hold_left = stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
      else if (hold_left != 0)
         hold_left = hold_left - 1;
      rsp_stall <= (hold_left != 0);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", idle_cycles);
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      int unsigned gap;
      gap = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   // pending is registered and lags the checker's queue, so the loop advances the clock before it reads pending.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      logic [SAMPLE_W-1:0] directed [24];
      logic [SAMPLE_W-1:0] ramp;
      logic [SAMPLE_W-1:0] step;
      logic [SAMPLE_W-1:0] base;
      logic [SAMPLE_W-1:0] s;
      sample_mix_type      mix;
      bit                  midway_paused;

      // fill-up with alternating extremes, then bit patterns, duplicates, falling run
      directed = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                   16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE,
                   16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'hF000,
                   16'hD000, 16'hB000, 16'h9000, 16'h7000, 16'h5000, 16'h3000};
      midway_paused = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_sample(directed[i]);
      drain();

      while (samples_sent < ITEM_TARGET) begin
         mix       = sample_mix_type'($urandom_range(0, 4));
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         ramp      = SAMPLE_W'($urandom);
         step      = SAMPLE_W'($urandom_range(1, 4096));
         base      = SAMPLE_W'($urandom);
         repeat ($urandom_range(8, 60)) begin
            case (mix)
               MIX_UNIFORM: s = SAMPLE_W'($urandom);
               MIX_CLUSTER: s = base + SAMPLE_W'($urandom_range(0, 3));
               MIX_EXTREME: s = $urandom_range(0, 1)
                                ? 16'hFFFF - SAMPLE_W'($urandom_range(0, 2))
                                : SAMPLE_W'($urandom_range(0, 2));
               MIX_RISING: begin
                  ramp = ramp + step;
                  s    = ramp;
               end
               default: begin
                  ramp = ramp - step;
                  s    = ramp;
               end
            endcase
            send_sample(s);
         end
         if (!midway_paused && samples_sent > ITEM_TARGET / 2) begin
            midway_paused = 1'b1;
            drain();
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d samples and %0d medians: window fill-up, wrap, duplicates,",
               samples_sent, medians_checked);
      $display("full-range, clustered, extreme and ramp streams under random gaps and stalls");
      if (fail_count == 0 && pending == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
